// ===== rtl/core/ecc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and helper functions of the collective car controller
// no dependencies
package ecc_pkg;

  localparam int MAX_FLOORS      = 64;
  localparam int MAX_PASSENGERS  = 16;
  localparam int FLOOR_W         = 7;
  localparam int TICK_W          = 16;
  localparam int PID_W           = 16;
  localparam int SLOT_IDX_W      = $clog2(MAX_PASSENGERS);
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  typedef logic [MAX_FLOORS:0] fmap_t;

  // motion codes
  localparam logic [2:0] MS_IDLE      = 3'd0;
  localparam logic [2:0] MS_UP        = 3'd1;
  localparam logic [2:0] MS_DOWN      = 3'd2;
  localparam logic [2:0] MS_STOPPED   = 3'd3;
  localparam logic [2:0] MS_BOARDING  = 3'd4;
  localparam logic [2:0] MS_ALIGHTING = 3'd5;

  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [2:0] FN_ADVANCE  = 3'd0;
  localparam logic [2:0] FN_ADD_HALL = 3'd1;
  localparam logic [2:0] FN_REM_HALL = 3'd2;
  localparam logic [2:0] FN_CAR_CALL = 3'd3;
  localparam logic [2:0] FN_REPOS    = 3'd4;
  localparam logic [2:0] FN_BOARD    = 3'd5;
  localparam logic [2:0] FN_ALIGHT   = 3'd6;
  localparam logic [2:0] FN_FINISH   = 3'd7;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_FLOOR   = 2'd1;
  localparam logic [1:0] EV_BOARDED = 2'd2;
  localparam logic [1:0] EV_ALIGHTED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_FLOOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAR_CAPACITY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERSON_TICKS = 3'd4;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_SCAN,
    SQ_EXEC,
    SQ_OUT
  } seq_state_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] cur_floor;
    logic [2:0]         mstate;
    logic [1:0]         dir;
    logic [TICK_W-1:0]  rem;
    logic [FLOOR_W-1:0] repo;
    fmap_t              upm;
    fmap_t              dnm;
    fmap_t              carm;
  } ctl_t;

  typedef struct packed {
    logic                  set_en;
    logic [SLOT_IDX_W-1:0] set_idx;
    logic [PID_W-1:0]      set_pid;
    logic [FLOOR_W-1:0]    set_dst;
    logic                  clr_en;
    logic [SLOT_IDX_W-1:0] clr_idx;
  } slot_wr_t;

  typedef struct packed {
    logic                  found;
    logic [SLOT_IDX_W-1:0] match_idx;
    logic [FLOOR_W-1:0]    match_dst;
    logic                  alight_here;
    logic [SLOT_IDX_W-1:0] free_idx;
  } scan_res_t;

  typedef struct packed {
    logic               accepted;
    logic [1:0]         event_kind;
    logic [PID_W-1:0]   event_passenger;
    logic [TICK_W-1:0]  elapsed_ticks;
    logic               empty_move;
    logic [FLOOR_W-1:0] car_floor;
    logic [2:0]         car_state;
    logic [1:0]         car_direction;
    logic [4:0]         aboard_count;
    logic [FLOOR_W-1:0] reposition_floor;
  } result_t;

  function automatic logic [FLOOR_W-1:0] fc_sat(input logic [FLOOR_W-1:0] raw);
    logic [FLOOR_W-1:0] f;
    f = raw;
    if (f < FLOOR_W'(2)) f = FLOOR_W'(2);
    if (f > FLOOR_W'(MAX_FLOORS)) f = FLOOR_W'(MAX_FLOORS);
    return f;
  endfunction

  function automatic logic [TICK_W-1:0] tick1(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  function automatic logic [1:0] dir_to(input logic [FLOOR_W-1:0] from,
                                        input logic [FLOOR_W-1:0] to);
    return (to > from) ? DIR_UP : ((to < from) ? DIR_DOWN : DIR_IDLE);
  endfunction

  function automatic logic map_bit(input fmap_t m, input logic [FLOOR_W-1:0] f);
    return (f <= FLOOR_W'(MAX_FLOORS)) ? m[f] : 1'b0;
  endfunction

  function automatic logic hall_here(input ctl_t c, input logic [FLOOR_W-1:0] f,
                                     input logic [1:0] d);
    logic r;
    r = 1'b0;
    if (d == DIR_UP) r = map_bit(c.upm, f);
    else if (d == DIR_DOWN) r = map_bit(c.dnm, f);
    return r;
  endfunction

  // any pending call strictly past the car in direction d (idle looks down)
  function automatic logic tasks_ahead(input ctl_t c, input logic [1:0] d);
    fmap_t any_m;
    fmap_t side;
    any_m = c.upm | c.dnm | c.carm;
    for (int f = 0; f <= MAX_FLOORS; f++) begin
      side[f] = (d == DIR_UP) ? (FLOOR_W'(f) > c.cur_floor) : (FLOOR_W'(f) < c.cur_floor);
    end
    return |(any_m & side);
  endfunction

  function automatic ctl_t choose_action(input ctl_t ci, input logic [TICK_W-1:0] mt);
    ctl_t c;
    logic done;
    c = ci;
    done = 1'b0;
    for (int a = 0; a < 2; a++) begin
      if (!done) begin
        if (map_bit(c.carm, c.cur_floor) || hall_here(c, c.cur_floor, c.dir)) begin
          c.mstate = MS_STOPPED;
          c.rem = '0;
          c.carm[c.cur_floor] = 1'b0;
          done = 1'b1;
        end else if (tasks_ahead(c, c.dir)) begin
          c.mstate = (c.dir == DIR_UP) ? MS_UP : MS_DOWN;
          c.rem = mt;
          done = 1'b1;
        end else begin
          c.dir = (c.dir == DIR_UP) ? DIR_DOWN : DIR_UP;
        end
      end
    end
    if (!done && c.repo != '0) begin
      if (c.repo == c.cur_floor) begin
        c.repo = '0;
      end else begin
        c.dir = dir_to(c.cur_floor, c.repo);
        c.mstate = (c.dir == DIR_UP) ? MS_UP : MS_DOWN;
        c.rem = mt;
        done = 1'b1;
      end
    end
    if (!done) begin
      c.dir = DIR_IDLE;
      c.mstate = MS_IDLE;
      c.rem = '0;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/ecc_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces: command, result and register write
// depends on ecc_pkg
interface ecc_in_if import ecc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [FLOOR_W-1:0] floor;
  logic               call_dir;
  logic [PID_W-1:0]   passenger_id;
  logic [TICK_W-1:0]  ticks;
  modport source (output valid, func, floor, call_dir, passenger_id, ticks, input ready);
  modport sink (input valid, func, floor, call_dir, passenger_id, ticks, output ready);
endinterface

interface ecc_out_if import ecc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [1:0]         event_kind;
  logic [PID_W-1:0]   event_passenger;
  logic [TICK_W-1:0]  elapsed_ticks;
  logic               empty_move;
  logic [FLOOR_W-1:0] car_floor;
  logic [2:0]         car_state;
  logic [1:0]         car_direction;
  logic [4:0]         aboard_count;
  logic [FLOOR_W-1:0] reposition_floor;
  modport source (output valid, accepted, event_kind, event_passenger, elapsed_ticks,
                  empty_move, car_floor, car_state, car_direction, aboard_count,
                  reposition_floor, input ready);
  modport sink (input valid, accepted, event_kind, event_passenger, elapsed_ticks,
                empty_move, car_floor, car_state, car_direction, aboard_count,
                reposition_floor, output ready);
endinterface

interface ecc_cfg_if import ecc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ecc_slot_scan.sv =====
`timescale 1ns / 1ps
// passenger slot table with a one-slot-per-cycle search unit
// depends on ecc_pkg
module ecc_slot_scan import ecc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [PID_W-1:0]   key,
  input  logic [FLOOR_W-1:0] cur_floor,
  input  slot_wr_t           wr,
  output logic               done,
  output scan_res_t          res
);
  localparam int NSLOT = MAX_PASSENGERS;
  localparam int IW = SLOT_IDX_W;

  logic [NSLOT-1:0]   valid_r;
  logic [PID_W-1:0]   pid_r [NSLOT];
  logic [FLOOR_W-1:0] dst_r [NSLOT];
  logic               busy_r;
  logic [IW-1:0]      idx_r;
  logic               free_found_r;
  scan_res_t          res_r;

  logic               v;
  logic [PID_W-1:0]   p;
  logic [FLOOR_W-1:0] d;

  assign v = valid_r[idx_r];
  assign p = pid_r[idx_r];
  assign d = dst_r[idx_r];
  assign done = busy_r && (idx_r == IW'(NSLOT - 1));
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      busy_r <= 1'b0;
      idx_r <= '0;
      free_found_r <= 1'b0;
      res_r <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        idx_r <= '0;
        free_found_r <= 1'b0;
        res_r <= '0;
      end else if (busy_r) begin
        if (v && p == key && !res_r.found) begin
          res_r.found <= 1'b1;
          res_r.match_idx <= idx_r;
          res_r.match_dst <= d;
        end
        if (v && d == cur_floor) res_r.alight_here <= 1'b1;
        if (!v && !free_found_r) begin
          free_found_r <= 1'b1;
          res_r.free_idx <= idx_r;
        end
        if (done) busy_r <= 1'b0;
        else idx_r <= idx_r + IW'(1);
      end
      if (wr.set_en) valid_r[wr.set_idx] <= 1'b1;
      if (wr.clr_en) valid_r[wr.clr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set_en) begin
      pid_r[wr.set_idx] <= wr.set_pid;
      dst_r[wr.set_idx] <= wr.set_dst;
    end
  end

endmodule

// ===== rtl/core/elevator_car_collective_control_top.sv =====
`timescale 1ns / 1ps
// Single-car collective controller: one command in, one status result out.
// After acceptance, a search unit walks the passenger slot table one slot
// per cycle, then the execute state applies the command and updates the call
// maps, then the result is held until taken. Input ready is low from
// acceptance until the result transaction completes, so a new command is not
// taken until the result of the last one has been taken. Register writes are
// accepted only while no command is in flight. No clearing pass is needed
// after reset.
module elevator_car_collective_control_top import ecc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ecc_in_if.sink    in_ch,
  ecc_out_if.source out_ch,
  ecc_cfg_if.sink   cfg_ch
);
  localparam int NSLOT = MAX_PASSENGERS;
  localparam int CW = $clog2(NSLOT + 1);
  localparam ctl_t CTL_RESET = '{cur_floor: FLOOR_W'(1), mstate: MS_IDLE, dir: DIR_IDLE,
                                 rem: '0, repo: '0, upm: '0, dnm: '0, carm: '0};

  seq_state_t st_r, st_nxt;
  ctl_t       ctl_r, ctl_nxt, ctl_cfg;
  result_t    res_r, res_nxt;

  logic [FLOOR_W-1:0] floor_count_r;
  logic [4:0]         capacity_r;
  logic [TICK_W-1:0]  move_ticks_r, person_ticks_r;

  logic [2:0]         func_r;
  logic [FLOOR_W-1:0] floor_r;
  logic               cdir_r;
  logic [PID_W-1:0]   pid_r;
  logic [TICK_W-1:0]  ticks_r;

  logic [PID_W-1:0]   pend_pid_r, pend_pid_nxt;
  logic [FLOOR_W-1:0] pend_dst_r, pend_dst_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;

  logic      in_acc, cfg_acc, scan_done;
  scan_res_t sres;
  slot_wr_t  swr;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = (st_r == SQ_IDLE);
  assign cfg_ch.ready = (st_r == SQ_IDLE);

  ecc_slot_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc),
    .key       ((func_r == FN_ADVANCE) ? pend_pid_r : pid_r),
    .cur_floor (ctl_r.cur_floor),
    .wr        (swr),
    .done      (scan_done),
    .res       (sres)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      SQ_IDLE: if (in_acc) st_nxt = SQ_SCAN;
      SQ_SCAN: if (scan_done) st_nxt = SQ_EXEC;
      SQ_EXEC: st_nxt = SQ_OUT;
      SQ_OUT:  if (out_ch.ready) st_nxt = SQ_IDLE;
      default: st_nxt = SQ_IDLE;
    endcase
  end

  // command execution in the SQ_EXEC state, in the cycle after the slot search ends
  always_comb begin
    logic [FLOOR_W-1:0] fcv;
    logic [7:0]         capv;
    logic [TICK_W-1:0]  mt, pt;
    logic               vf;
    logic [1:0]         cd;
    ctl_t               c;
    c = ctl_r;
    fcv = fc_sat(floor_count_r);
    capv = 8'(capacity_r);
    if (capv == 8'd0) capv = 8'd1;
    if (capv > 8'(NSLOT)) capv = 8'(NSLOT);
    mt = tick1(move_ticks_r);
    pt = tick1(person_ticks_r);
    vf = (floor_r >= FLOOR_W'(1)) && (floor_r <= fcv);
    cd = cdir_r ? DIR_DOWN : DIR_UP;
    res_nxt = '0;
    pend_pid_nxt = pend_pid_r;
    pend_dst_nxt = pend_dst_r;
    cnt_nxt = cnt_r;
    swr = '0;
    case (func_r)
      FN_ADVANCE: begin
        res_nxt.accepted = 1'b1;
        if (ticks_r != '0) begin
          res_nxt.elapsed_ticks = ticks_r;
          if (c.mstate != MS_IDLE && c.mstate != MS_STOPPED) begin
            if (ticks_r < c.rem) begin
              c.rem = c.rem - ticks_r;
            end else begin
              res_nxt.elapsed_ticks = c.rem;
              c.rem = '0;
              if (c.mstate == MS_UP || c.mstate == MS_DOWN) begin
                res_nxt.event_kind = EV_FLOOR;
                res_nxt.empty_move = (cnt_r == '0);
                if (c.dir == DIR_UP) begin
                  if (c.cur_floor < fcv) c.cur_floor = c.cur_floor + FLOOR_W'(1);
                end else if (c.cur_floor > FLOOR_W'(1)) begin
                  c.cur_floor = c.cur_floor - FLOOR_W'(1);
                end
                c = choose_action(c, mt);
              end else begin
                res_nxt.event_passenger = pend_pid_r;
                if (c.mstate == MS_BOARDING) begin
                  res_nxt.event_kind = EV_BOARDED;
                  swr.set_en = 1'b1;
                  swr.set_idx = sres.free_idx;
                  swr.set_pid = pend_pid_r;
                  swr.set_dst = pend_dst_r;
                  cnt_nxt = cnt_r + CW'(1);
                  if (pend_dst_r >= FLOOR_W'(1) && pend_dst_r <= fcv) begin
                    c.carm[pend_dst_r] = 1'b1;
                  end
                end else begin
                  res_nxt.event_kind = EV_ALIGHTED;
                  if (sres.found) begin
                    swr.clr_en = 1'b1;
                    swr.clr_idx = sres.match_idx;
                    cnt_nxt = cnt_r - CW'(1);
                  end
                end
                pend_pid_nxt = '0;
                pend_dst_nxt = '0;
                c.mstate = MS_STOPPED;
              end
            end
          end
        end
      end
      FN_ADD_HALL: begin
        if (vf && !(floor_r == FLOOR_W'(1) && cd == DIR_DOWN) &&
            !(floor_r == fcv && cd == DIR_UP)) begin
          res_nxt.accepted = 1'b1;
          c.repo = '0;
          if (cd == DIR_UP) c.upm[floor_r] = 1'b1;
          else c.dnm[floor_r] = 1'b1;
          if (c.mstate == MS_IDLE) begin
            c.dir = (floor_r == c.cur_floor) ? cd : dir_to(c.cur_floor, floor_r);
            c = choose_action(c, mt);
          end
        end
      end
      FN_REM_HALL: begin
        if (hall_here(c, floor_r, cd) &&
            !(floor_r == c.cur_floor && (c.mstate == MS_STOPPED ||
              c.mstate == MS_BOARDING || c.mstate == MS_ALIGHTING))) begin
          res_nxt.accepted = 1'b1;
          if (cd == DIR_UP) c.upm[floor_r] = 1'b0;
          else c.dnm[floor_r] = 1'b0;
        end
      end
      FN_CAR_CALL: begin
        if (vf && floor_r != c.cur_floor) begin
          res_nxt.accepted = 1'b1;
          c.repo = '0;
          c.carm[floor_r] = 1'b1;
          if (c.mstate == MS_IDLE) begin
            c.dir = dir_to(c.cur_floor, floor_r);
            c = choose_action(c, mt);
          end
        end
      end
      FN_REPOS: begin
        if (vf && floor_r != c.cur_floor && c.mstate == MS_IDLE && cnt_r == '0 &&
            !(|(c.upm | c.dnm | c.carm))) begin
          res_nxt.accepted = 1'b1;
          c.repo = floor_r;
          c.dir = dir_to(c.cur_floor, floor_r);
          c = choose_action(c, mt);
        end
      end
      FN_BOARD: begin
        if (c.mstate == MS_STOPPED && 8'(cnt_r) < capv && !sres.found && vf &&
            floor_r != c.cur_floor && dir_to(c.cur_floor, floor_r) == c.dir &&
            !sres.alight_here) begin
          res_nxt.accepted = 1'b1;
          pend_pid_nxt = pid_r;
          pend_dst_nxt = floor_r;
          c.mstate = MS_BOARDING;
          c.rem = pt;
        end
      end
      FN_ALIGHT: begin
        if (c.mstate == MS_STOPPED && sres.found && sres.match_dst == c.cur_floor) begin
          res_nxt.accepted = 1'b1;
          pend_pid_nxt = pid_r;
          c.mstate = MS_ALIGHTING;
          c.rem = pt;
        end
      end
      FN_FINISH: begin
        if (c.mstate == MS_STOPPED && !sres.alight_here) begin
          res_nxt.accepted = 1'b1;
          if (c.dir == DIR_UP) c.upm[c.cur_floor] = 1'b0;
          else c.dnm[c.cur_floor] = 1'b0;
          c.carm[c.cur_floor] = 1'b0;
          c = choose_action(c, mt);
        end
      end
      default: ;
    endcase
    ctl_nxt = c;
    res_nxt.car_floor = c.cur_floor;
    res_nxt.car_state = c.mstate;
    res_nxt.car_direction = c.dir;
    res_nxt.aboard_count = 5'(cnt_nxt);
    res_nxt.reposition_floor = c.repo;
    if (st_r != SQ_EXEC) swr = '0;
  end

  // side effects of register writes on the car state
  always_comb begin
    logic [FLOOR_W-1:0] fcn, sf, fcc;
    ctl_cfg = ctl_r;
    fcn = fc_sat(cfg_ch.data[FLOOR_W-1:0]);
    fcc = fc_sat(floor_count_r);
    sf = cfg_ch.data[FLOOR_W-1:0];
    if (sf < FLOOR_W'(1)) sf = FLOOR_W'(1);
    if (sf > fcc) sf = fcc;
    case (cfg_ch.index)
      REG_FLOOR_COUNT: begin
        for (int f = 0; f <= MAX_FLOORS; f++) begin
          if (FLOOR_W'(f) > fcn) begin
            ctl_cfg.upm[f] = 1'b0;
            ctl_cfg.dnm[f] = 1'b0;
            ctl_cfg.carm[f] = 1'b0;
          end
        end
        if (ctl_r.repo > fcn) ctl_cfg.repo = '0;
        if (ctl_r.cur_floor > fcn) ctl_cfg.cur_floor = fcn;
      end
      REG_START_FLOOR: begin
        if (ctl_r.mstate == MS_IDLE) begin
          ctl_cfg.cur_floor = sf;
          if (ctl_r.repo == sf) ctl_cfg.repo = '0;
        end
      end
      default: ;
    endcase
  end

  // the start floor is not stored: a write moves an idle car there, and reset always restores floor 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SQ_IDLE;
      ctl_r <= CTL_RESET;
      floor_count_r <= FLOOR_W'(16);
      capacity_r <= 5'd8;
      move_ticks_r <= TICK_W'(100);
      person_ticks_r <= TICK_W'(50);
      pend_pid_r <= '0;
      pend_dst_r <= '0;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == SQ_EXEC) begin
        ctl_r <= ctl_nxt;
        pend_pid_r <= pend_pid_nxt;
        pend_dst_r <= pend_dst_nxt;
        cnt_r <= cnt_nxt;
      end else if (cfg_acc) begin
        ctl_r <= ctl_cfg;
        case (cfg_ch.index)
          REG_FLOOR_COUNT:  floor_count_r <= cfg_ch.data[FLOOR_W-1:0];
          REG_CAR_CAPACITY: capacity_r <= cfg_ch.data[4:0];
          REG_MOVE_TICKS:   move_ticks_r <= cfg_ch.data[TICK_W-1:0];
          REG_PERSON_TICKS: person_ticks_r <= cfg_ch.data[TICK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_ch.func;
      floor_r <= in_ch.floor;
      cdir_r <= in_ch.call_dir;
      pid_r <= in_ch.passenger_id;
      ticks_r <= in_ch.ticks;
    end
    if (st_r == SQ_EXEC) res_r <= res_nxt;
  end

  assign out_ch.valid            = (st_r == SQ_OUT);
  assign out_ch.accepted         = res_r.accepted;
  assign out_ch.event_kind       = res_r.event_kind;
  assign out_ch.event_passenger  = res_r.event_passenger;
  assign out_ch.elapsed_ticks    = res_r.elapsed_ticks;
  assign out_ch.empty_move       = res_r.empty_move;
  assign out_ch.car_floor        = res_r.car_floor;
  assign out_ch.car_state        = res_r.car_state;
  assign out_ch.car_direction    = res_r.car_direction;
  assign out_ch.aboard_count     = res_r.aboard_count;
  assign out_ch.reposition_floor = res_r.reposition_floor;

endmodule

// ===== test/ecc_checker.sv =====
`timescale 1ns / 1ps
// result checker for the collective car controller: watches the three channels,
// keeps its own model of the car and compares every result transaction
// depends on ecc_pkg and the channel interfaces in ecc_if.sv
module ecc_checker import ecc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ecc_in_if    in_ch,
  ecc_out_if   out_ch,
  ecc_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);

  // register copies, kept raw as written
  logic [6:0]  r_floors;
  logic [6:0]  r_start;
  logic [4:0]  r_cap;
  logic [15:0] r_move;
  logic [15:0] r_person;

  bit [MAX_FLOORS:0] up_calls, down_calls, car_calls;
  logic [6:0]  car_at;
  logic [2:0]  motion;
  logic [1:0]  heading;
  logic [15:0] ticks_left;
  logic [6:0]  park_floor;
  logic [15:0] wait_pid;
  logic [6:0]  wait_dest;
  bit          seat_used [MAX_PASSENGERS];
  logic [15:0] seat_pid  [MAX_PASSENGERS];
  logic [6:0]  seat_dest [MAX_PASSENGERS];

  result_t expected_status [$];
  int      mismatches;

  assign fail_count = mismatches;
  assign pending    = expected_status.size();

  function automatic int floors_served();
    int f;
    f = r_floors;
    if (f < 2) f = 2;
    if (f > MAX_FLOORS) f = MAX_FLOORS;
    return f;
  endfunction

  function automatic int seats();
    int c;
    c = r_cap;
    if (c < 1) c = 1;
    if (c > MAX_PASSENGERS) c = MAX_PASSENGERS;
    return c;
  endfunction

  function automatic logic [15:0] nonzero(logic [15:0] v);
    return (v == 0) ? 16'd1 : v;
  endfunction

  function automatic bit floor_ok(int f);
    return f >= 1 && f <= floors_served();
  endfunction

  function automatic logic [1:0] toward(int from, int dst);
    return (dst > from) ? DIR_UP : ((dst < from) ? DIR_DOWN : DIR_IDLE);
  endfunction

  function automatic int riders();
    int n;
    n = 0;
    for (int i = 0; i < MAX_PASSENGERS; i++) if (seat_used[i]) n++;
    return n;
  endfunction

  function automatic int seat_of(logic [15:0] id);
    for (int i = 0; i < MAX_PASSENGERS; i++)
      if (seat_used[i] && seat_pid[i] == id) return i;
    return -1;
  endfunction

  function automatic bit leaving_here();
    for (int i = 0; i < MAX_PASSENGERS; i++)
      if (seat_used[i] && seat_dest[i] == car_at) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit hall_call_at(int f, logic [1:0] d);
    if (f > MAX_FLOORS) return 1'b0;
    if (d == DIR_UP) return up_calls[f];
    if (d == DIR_DOWN) return down_calls[f];
    return 1'b0;
  endfunction

  function automatic bit calls_beyond(logic [1:0] d);
    for (int f = 1; f <= MAX_FLOORS; f++)
      if ((up_calls[f] || down_calls[f] || car_calls[f]) &&
          ((d == DIR_UP) ? (f > car_at) : (f < car_at))) return 1'b1;
    return 1'b0;
  endfunction

  // decide what the car does next from the current floor
  function automatic void next_move();
    for (int a = 0; a < 2; a++) begin
      if (car_calls[car_at] || hall_call_at(car_at, heading)) begin
        motion = MS_STOPPED;
        ticks_left = 0;
        car_calls[car_at] = 1'b0;
        return;
      end
      if (calls_beyond(heading)) begin
        motion = (heading == DIR_UP) ? MS_UP : MS_DOWN;
        ticks_left = nonzero(r_move);
        return;
      end
      heading = (heading == DIR_UP) ? DIR_DOWN : DIR_UP;
    end
    if (park_floor != 0) begin
      if (park_floor == car_at) begin
        park_floor = 0;
      end else begin
        heading = toward(car_at, park_floor);
        motion = (heading == DIR_UP) ? MS_UP : MS_DOWN;
        ticks_left = nonzero(r_move);
        return;
      end
    end
    heading = DIR_IDLE;
    motion = MS_IDLE;
    ticks_left = 0;
  endfunction

  function automatic void reset_car();
    r_floors = 7'd16; r_start = 7'd1; r_cap = 5'd8; r_move = 16'd100; r_person = 16'd50;
    up_calls = '0; down_calls = '0; car_calls = '0;
    for (int i = 0; i < MAX_PASSENGERS; i++) begin
      seat_used[i] = 1'b0; seat_pid[i] = '0; seat_dest[i] = '0;
    end
    car_at = r_start;
    motion = MS_IDLE; heading = DIR_IDLE; ticks_left = 0; park_floor = 0;
    wait_pid = 0; wait_dest = 0;
  endfunction

  function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    int f;
    case (idx)
      REG_FLOOR_COUNT: begin
        r_floors = v[6:0];
        for (int k = floors_served() + 1; k <= MAX_FLOORS; k++) begin
          up_calls[k] = 1'b0; down_calls[k] = 1'b0; car_calls[k] = 1'b0;
        end
        if (park_floor > floors_served()) park_floor = 0;
        if (car_at > floors_served()) car_at = floors_served();
      end
      REG_START_FLOOR: begin
        r_start = v[6:0];
        if (motion == MS_IDLE) begin
          f = r_start;
          if (f < 1) f = 1;
          if (f > floors_served()) f = floors_served();
          car_at = f;
          if (park_floor == car_at) park_floor = 0;
        end
      end
      REG_CAR_CAPACITY: r_cap = v[4:0];
      REG_MOVE_TICKS:   r_move = v;
      REG_PERSON_TICKS: r_person = v;
      default: ;
    endcase
  endfunction

  function automatic result_t apply_command(logic [2:0] fn, int fl, logic dbit,
                                            logic [15:0] pid, logic [15:0] tk);
    result_t r;
    logic [1:0] cd;
    int s;
    r = '0;
    cd = dbit ? DIR_DOWN : DIR_UP;
    case (fn)
      FN_ADVANCE: begin
        r.accepted = 1'b1;
        if (tk != 0) begin
          r.elapsed_ticks = tk;
          if (motion != MS_IDLE && motion != MS_STOPPED) begin
            if (tk < ticks_left) begin
              ticks_left -= tk;
            end else begin
              r.elapsed_ticks = ticks_left;
              ticks_left = 0;
              if (motion == MS_UP || motion == MS_DOWN) begin
                r.event_kind = EV_FLOOR;
                r.empty_move = (riders() == 0);
                if (heading == DIR_UP) begin
                  if (car_at < floors_served()) car_at++;
                end else if (car_at > 1) car_at--;
                next_move();
              end else begin
                r.event_passenger = wait_pid;
                if (motion == MS_BOARDING) begin
                  r.event_kind = EV_BOARDED;
                  for (int i = 0; i < MAX_PASSENGERS; i++) begin
                    if (!seat_used[i]) begin
                      seat_used[i] = 1'b1; seat_pid[i] = wait_pid; seat_dest[i] = wait_dest;
                      break;
                    end
                  end
                  if (floor_ok(wait_dest)) car_calls[wait_dest] = 1'b1;
                end else begin
                  r.event_kind = EV_ALIGHTED;
                  s = seat_of(wait_pid);
                  if (s >= 0) seat_used[s] = 1'b0;
                end
                wait_pid = 0; wait_dest = 0;
                motion = MS_STOPPED;
              end
            end
          end
        end
      end
      FN_ADD_HALL: begin
        if (floor_ok(fl) && !(fl == 1 && cd == DIR_DOWN) &&
            !(fl == floors_served() && cd == DIR_UP)) begin
          r.accepted = 1'b1;
          park_floor = 0;
          if (cd == DIR_UP) up_calls[fl] = 1'b1; else down_calls[fl] = 1'b1;
          if (motion == MS_IDLE) begin
            heading = (fl == car_at) ? cd : toward(car_at, fl);
            next_move();
          end
        end
      end
      FN_REM_HALL: begin
        if (hall_call_at(fl, cd) && !(fl == car_at && (motion == MS_STOPPED ||
            motion == MS_BOARDING || motion == MS_ALIGHTING))) begin
          r.accepted = 1'b1;
          if (cd == DIR_UP) up_calls[fl] = 1'b0; else down_calls[fl] = 1'b0;
        end
      end
      FN_CAR_CALL: begin
        if (floor_ok(fl) && fl != car_at) begin
          r.accepted = 1'b1;
          park_floor = 0;
          car_calls[fl] = 1'b1;
          if (motion == MS_IDLE) begin
            heading = toward(car_at, fl);
            next_move();
          end
        end
      end
      FN_REPOS: begin
        if (floor_ok(fl) && fl != car_at && motion == MS_IDLE && riders() == 0 &&
            (up_calls | down_calls | car_calls) == '0) begin
          r.accepted = 1'b1;
          park_floor = fl;
          heading = toward(car_at, fl);
          next_move();
        end
      end
      FN_BOARD: begin
        if (motion == MS_STOPPED && riders() < seats() && seat_of(pid) < 0 &&
            floor_ok(fl) && fl != car_at && toward(car_at, fl) == heading &&
            !leaving_here()) begin
          r.accepted = 1'b1;
          wait_pid = pid; wait_dest = fl;
          motion = MS_BOARDING;
          ticks_left = nonzero(r_person);
        end
      end
      FN_ALIGHT: begin
        s = seat_of(pid);
        if (motion == MS_STOPPED && s >= 0 && seat_dest[s] == car_at) begin
          r.accepted = 1'b1;
          wait_pid = pid;
          motion = MS_ALIGHTING;
          ticks_left = nonzero(r_person);
        end
      end
      default: begin
        if (motion == MS_STOPPED && !leaving_here()) begin
          r.accepted = 1'b1;
          if (heading == DIR_UP) up_calls[car_at] = 1'b0;
          else down_calls[car_at] = 1'b0;
          car_calls[car_at] = 1'b0;
          next_move();
        end
      end
    endcase
    r.car_floor = car_at;
    r.car_state = motion;
    r.car_direction = heading;
    r.aboard_count = 5'(riders());
    r.reposition_floor = park_floor;
    return r;
  endfunction

  function automatic string first_bad_field(result_t e, result_t a);
    if (e.accepted !== a.accepted) return "accepted";
    if (e.event_kind !== a.event_kind) return "event_kind";
    if (e.event_passenger !== a.event_passenger) return "event_passenger";
    if (e.elapsed_ticks !== a.elapsed_ticks) return "elapsed_ticks";
    if (e.empty_move !== a.empty_move) return "empty_move";
    if (e.car_floor !== a.car_floor) return "car_floor";
    if (e.car_state !== a.car_state) return "car_state";
    if (e.car_direction !== a.car_direction) return "car_direction";
    if (e.aboard_count !== a.aboard_count) return "aboard_count";
    if (e.reposition_floor !== a.reposition_floor) return "reposition_floor";
    return "";
  endfunction

  always @(posedge clk) begin
    result_t seen, want;
    string bad;
    if (!rst_n) begin
      reset_car();
      expected_status.delete();
      mismatches <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        expected_status.insert(expected_status.size(),
                               apply_command(in_ch.func, in_ch.floor, in_ch.call_dir,
                                             in_ch.passenger_id, in_ch.ticks));
      if (out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.accepted, out_ch.event_kind, out_ch.event_passenger,
                 out_ch.elapsed_ticks, out_ch.empty_move, out_ch.car_floor,
                 out_ch.car_state, out_ch.car_direction, out_ch.aboard_count,
                 out_ch.reposition_floor};
        if (expected_status.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transaction %p", seen);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_status.pop_front();
          bad = first_bad_field(want, seen);
          if (bad != "") begin
            if (mismatches < 10)
              $display("mismatch in %s: expected %p actual %p", bad, want, seen);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// top of the collective car controller testbench: clock, reset, register
// phases, directed and random command traffic, verdict
// depends on ecc_pkg, ecc_if.sv, the controller top and ecc_checker
module tb import ecc_pkg::*; ();

  localparam int STALL_LIMIT = 20000;
  localparam int PER_PHASE   = 260;

  logic clk;
  logic rst_n;
  int   fail_count, pending;
  int   idle_mode;
  int   stall_cycles;
  int   served;
  int   sent;
  logic [15:0] riders_pool [6];
  logic [15:0] step_ticks;

  ecc_in_if  in_ch();
  ecc_out_if out_ch();
  ecc_cfg_if cfg_ch();

  elevator_car_collective_control_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  ecc_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // receiver stalls: 80% in mode 0, 33% in mode 1, none in mode 2
  always @(posedge clk) begin
    case (idle_mode)
      0: out_ch.ready <= ($urandom_range(0, 99) >= 80);
      1: out_ch.ready <= ($urandom_range(0, 99) >= 33);
      default: out_ch.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic hold_off(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    hold_off(1);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send(logic [2:0] fn, logic [6:0] fl, logic d, logic [15:0] pid,
                      logic [15:0] tk);
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.floor <= fl;
    in_ch.call_dir <= d;
    in_ch.passenger_id <= pid;
    in_ch.ticks <= tk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    // sender gaps: 33% in mode 0, 80% in mode 1
    if ((idle_mode == 0 && $urandom_range(0, 99) < 33) ||
        (idle_mode == 1 && $urandom_range(0, 99) < 80))
      hold_off($urandom_range(1, 6));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // upper bits beyond a register's width are random junk
  task automatic load_regs(int fcount, int start, int cap, int mv, int ps);
    int f;
    drain();
    write_reg(REG_FLOOR_COUNT, {9'($urandom), 7'(fcount)});
    write_reg(REG_START_FLOOR, {9'($urandom), 7'(start)});
    write_reg(REG_CAR_CAPACITY, {11'($urandom), 5'(cap)});
    write_reg(REG_MOVE_TICKS, 16'(mv));
    write_reg(REG_PERSON_TICKS, 16'(ps));
    f = fcount;
    if (f < 2) f = 2;
    if (f > MAX_FLOORS) f = MAX_FLOORS;
    served = f;
    step_ticks = (mv > ps) ? 16'(mv) : 16'(ps);
  endtask

  task automatic random_command();
    logic [2:0]  fn;
    logic [6:0]  fl;
    logic [15:0] pid, tk;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) fn = FN_ADVANCE;
    else if (pick < 50) fn = FN_ADD_HALL;
    else if (pick < 55) fn = FN_REM_HALL;
    else if (pick < 65) fn = FN_CAR_CALL;
    else if (pick < 70) fn = FN_REPOS;
    else if (pick < 82) fn = FN_BOARD;
    else if (pick < 91) fn = FN_ALIGHT;
    else fn = FN_FINISH;
    if ($urandom_range(0, 99) < 85) fl = 7'($urandom_range(1, served + 1));
    else fl = 7'($urandom);
    if ($urandom_range(0, 99) < 90) pid = riders_pool[$urandom_range(0, 5)];
    else pid = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) tk = 0;
    else if (pick < 75 && step_ticks < 16'd30000)
      tk = 16'($urandom_range(1, 2 * step_ticks + 2));
    else tk = 16'($urandom);
    send(fn, fl, 1'($urandom), pid, tk);
  endtask

  task automatic random_phase();
    for (int k = 0; k < PER_PHASE; k++) begin
      idle_mode = (sent < 450) ? 0 : ((sent < 900) ? 1 : 2);
      if (k == PER_PHASE / 2) drain();
      random_command();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    idle_mode = 0;
    sent = 0;
    served = 16;
    step_ticks = 16'd100;
    in_ch.valid = 1'b0;
    in_ch.func = FN_ADVANCE;
    in_ch.floor = '0;
    in_ch.call_dir = 1'b0;
    in_ch.passenger_id = '0;
    in_ch.ticks = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    riders_pool = '{16'd0, 16'hFFFF, 16'h5A5A, 16'hA5A5, 16'd7, 16'h1234};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, refusals, ends of the range, a full stop cycle
    send(FN_ADVANCE, 7'd1, 1'b0, 16'd0, 16'd0);
    send(FN_ADVANCE, 7'd1, 1'b0, 16'd0, 16'hFFFF);
    send(FN_ADD_HALL, 7'd1, 1'b1, 16'd0, 16'd1);
    send(FN_ADD_HALL, 7'd16, 1'b0, 16'd0, 16'd1);
    send(FN_ADD_HALL, 7'd0, 1'b0, 16'd0, 16'd1);
    send(FN_CAR_CALL, 7'd1, 1'b0, 16'd0, 16'd1);
    send(FN_REPOS, 7'd16, 1'b0, 16'd0, 16'd1);
    send(FN_ADVANCE, 7'd1, 1'b0, 16'd0, 16'd99);
    send(FN_ADD_HALL, 7'd2, 1'b0, 16'd0, 16'd1);
    send(FN_ADVANCE, 7'd1, 1'b0, 16'd0, 16'hFFFF);
    send(FN_ADVANCE, 7'd1, 1'b0, 16'd0, 16'hFFFF);
    send(FN_REM_HALL, 7'd2, 1'b0, 16'd0, 16'd1);
    send(FN_BOARD, 7'd5, 1'b0, 16'hFFFF, 16'd1);
    send(FN_BOARD, 7'd5, 1'b0, 16'hFFFF, 16'd1);
    send(FN_ADVANCE, 7'd1, 1'b0, 16'd0, 16'd100);
    send(FN_BOARD, 7'd5, 1'b0, 16'hFFFF, 16'd1);
    send(FN_FINISH, 7'd1, 1'b0, 16'd0, 16'd1);
    send(FN_ADVANCE, 7'd1, 1'b0, 16'd0, 16'hFFFF);
    send(FN_ADVANCE, 7'd1, 1'b0, 16'd0, 16'hFFFF);
    send(FN_ADVANCE, 7'd1, 1'b0, 16'd0, 16'hFFFF);
    send(FN_ALIGHT, 7'd1, 1'b0, 16'd9, 16'd1);
    send(FN_ALIGHT, 7'd1, 1'b0, 16'hFFFF, 16'd1);
    send(FN_ADVANCE, 7'd1, 1'b0, 16'd0, 16'hFFFF);
    send(FN_FINISH, 7'd1, 1'b0, 16'd0, 16'd1);
    send(FN_ADD_HALL, 7'd64, 1'b1, 16'd0, 16'd1);

    load_regs(6, 3, 2, 3, 2);
    random_phase();
    // out of range values saturate
    load_regs(127, 100, 31, 0, 0);
    random_phase();
    load_regs(0, 0, 0, 2, 3);
    random_phase();
    load_regs(64, 1, 16, 65535, 65535);
    random_phase();
    load_regs(9, 5, 4, 4, 2);
    random_phase();
    // lowering the floor count while the car may be busy
    load_regs(3, 2, 1, 1, 1);
    for (int k = 0; k < 40; k++) random_command();

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== elevator_car_collective_control_top.f =====
rtl/core/ecc_pkg.sv
rtl/core/ecc_if.sv
rtl/core/ecc_slot_scan.sv
rtl/core/elevator_car_collective_control_top.sv
test/ecc_checker.sv
test/tb.sv
